/* rtl/tfbs_pkg.sv */
// Shared types and constants for the TFTP block sender.
// Used by every module of the block; no dependencies.
package tfbs_pkg;

  localparam int MaxBlockBytes = 512;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;
  localparam int InDataW = 72;
  localparam int OutDataW = 32;

  localparam logic [7:0] OpAck = 8'h04;
  localparam logic [7:0] OpErr = 8'h05;

  localparam logic [5:0] RetryLimitRst = 6'd50;
  localparam logic [19:0] TimeoutRst = 20'd100000;
  localparam logic [9:0] HeaderBytes = 10'd4;

  typedef enum logic [1:0] {
    CmdChunk  = 2'd0,
    CmdPacket = 2'd1,
    CmdTick   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CfgClient  = 2'd0,
    CfgRetry   = 2'd1,
    CfgTimeout = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActSend    = 3'd1,
    ActResend  = 3'd2,
    ActIllegal = 3'd3,
    ActNext    = 3'd4,
    ActDone    = 3'd5,
    ActAbort   = 3'd6
  } act_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  chunk_length;
    logic        last_chunk;
    logic [31:0] source_address;
    logic [7:0]  packet_opcode;
    logic [15:0] acked_block;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] data_block;
    logic [9:0]  packet_length;
  } res_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

/* rtl/tfbs_in_stage.sv */
// Input register of the TFTP block sender.
// Holds one accepted item until the engine takes it; uses tfbs_pkg.
module tfbs_in_stage import tfbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

/* rtl/tfbs_engine.sv */
// Transfer state, configuration registers and per-item decision logic.
// Produces one result per processed item; uses tfbs_pkg.
module tfbs_engine import tfbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output res_t    res_o
);

  localparam logic [9:0] MaxLen = 10'(MaxBlockBytes);

  logic [31:0] client_q;
  logic [5:0]  limit_q;
  logic [19:0] timeout_q;

  logic [15:0] block_q, block_d;
  logic [5:0]  retry_q, retry_d;
  logic [19:0] timer_q, timer_d;
  logic        wait_q, wait_d;
  logic [9:0]  len_q, len_d;
  logic        last_q, last_d;

  logic [5:0]  retry_inc;
  logic [19:0] timer_inc;
  logic        limit_hit;
  logic        len_big;
  act_e        act;
  logic [15:0] shown;

  assign retry_inc = retry_q + 6'd1;
  assign timer_inc = timer_q + 20'd1;
  assign limit_hit = retry_inc >= limit_q;
  assign len_big   = 32'(item_i.chunk_length) > 32'(MaxBlockBytes);

  always_comb begin
    block_d = block_q;
    retry_d = retry_q;
    timer_d = timer_q;
    wait_d  = wait_q;
    len_d   = len_q;
    last_d  = last_q;
    act     = ActNone;
    shown   = block_q;
    unique case (item_i.command)
      CmdChunk: begin
        if (!wait_q) begin
          block_d = block_q + 16'd1;
          len_d   = len_big ? MaxLen : item_i.chunk_length;
          last_d  = item_i.last_chunk;
          retry_d = '0;
          timer_d = '0;
          wait_d  = 1'b1;
          act     = ActSend;
          shown   = block_d;
        end
      end
      CmdPacket: begin
        if (wait_q) begin
          if (item_i.source_address != client_q) begin
            timer_d = '0;
          end else if (item_i.packet_opcode != OpAck || item_i.acked_block != block_q) begin
            timer_d = '0;
            if (limit_hit) begin
              block_d = '0;
              retry_d = '0;
              wait_d  = 1'b0;
              act     = ActAbort;
            end else begin
              retry_d = retry_inc;
              act     = (item_i.packet_opcode > OpErr) ? ActIllegal : ActNone;
            end
          end else if (last_q) begin
            block_d = '0;
            retry_d = '0;
            timer_d = '0;
            wait_d  = 1'b0;
            act     = ActDone;
          end else begin
            retry_d = '0;
            timer_d = '0;
            wait_d  = 1'b0;
            act     = ActNext;
          end
        end
      end
      CmdTick: begin
        if (wait_q) begin
          if (timer_inc >= timeout_q) begin
            timer_d = '0;
            if (limit_hit) begin
              block_d = '0;
              retry_d = '0;
              wait_d  = 1'b0;
              act     = ActAbort;
            end else begin
              retry_d = retry_inc;
              act     = ActResend;
            end
          end else begin
            timer_d = timer_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.action        = act;
    res_o.data_block    = shown;
    res_o.packet_length = (act == ActSend || act == ActResend) ? len_d + HeaderBytes : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      client_q  <= '0;
      limit_q   <= RetryLimitRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        CfgClient:  client_q  <= cfg_i.data;
        CfgRetry:   limit_q   <= cfg_i.data[5:0];
        CfgTimeout: timeout_q <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_q <= '0;
      retry_q <= '0;
      timer_q <= '0;
      wait_q  <= 1'b0;
      len_q   <= '0;
      last_q  <= 1'b0;
    end else if (step_i) begin
      block_q <= block_d;
      retry_q <= retry_d;
      timer_q <= timer_d;
      wait_q  <= wait_d;
      len_q   <= len_d;
      last_q  <= last_d;
    end
  end

endmodule

/* rtl/tfbs_out_stage.sv */
// Result register of the TFTP block sender.
// Holds one result until the downstream side takes it; uses tfbs_pkg.
module tfbs_out_stage import tfbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  output logic ready_o,
  input  res_t res_i,
  output logic valid_o,
  input  logic take_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* rtl/tftp_block_sender.sv */
// Sending side of a TFTP read transfer: numbers data blocks, times out and
// resends, checks acknowledgements. One item is accepted per clock cycle while
// the result register is not stalled; an item is held in the input register
// and is decided against the transfer state on its way into the result
// register. A stalled result register holds back at most one item.
// Uses tfbs_pkg, tfbs_in_stage, tfbs_engine and tfbs_out_stage.
module tftp_block_sender import tfbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // chunk_length[9:0], source_address[41:10], packet_opcode[49:42],
  // acked_block[65:50], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tlast_i, // last_chunk
  input  logic [1:0]          s_axis_tuser_i, // command
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // data_block[15:0], packet_length[25:16], zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic [2:0]          m_axis_tuser_o  // action
);

  item_t   in_item, cur_item;
  res_t    res_d, res_q;
  cfg_wr_t cfg;
  logic    cur_valid, out_ready, step;

  assign in_item.command        = s_axis_tuser_i;
  assign in_item.chunk_length   = s_axis_tdata_i[9:0];
  assign in_item.last_chunk     = s_axis_tlast_i;
  assign in_item.source_address = s_axis_tdata_i[41:10];
  assign in_item.packet_opcode  = s_axis_tdata_i[49:42];
  assign in_item.acked_block    = s_axis_tdata_i[65:50];

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  assign step = cur_valid && out_ready;

  tfbs_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (step),
    .item_o  (cur_item)
  );

  tfbs_engine u_eng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (cur_item),
    .res_o  (res_d)
  );

  tfbs_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .ready_o (out_ready),
    .res_i   (res_d),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .res_o   (res_q)
  );

  assign m_axis_tdata_o = {6'd0, res_q.packet_length, res_q.data_block};
  assign m_axis_tuser_o = res_q.action;

endmodule

/* rtl/tfbs_checker.sv */
// Port-level checks for tftp_block_sender, attached by bind.
// Uses tfbs_pkg.
module tfbs_checker import tfbs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic [2:0]          m_axis_tuser_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // input backpressure only while a result is pending
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output");

  // sends carry a valid length
  a_send_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ActSend || m_axis_tuser_o == ActResend) |->
      m_axis_tdata_o[25:16] >= 10'd4 && m_axis_tdata_o[25:16] <= 10'd516)
    else $error("bad packet length on send");

  // other actions carry no length
  a_other_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ActSend && m_axis_tuser_o != ActResend |->
      m_axis_tdata_o[25:16] == 10'd0 && m_axis_tuser_o != 3'd7)
    else $error("length on non-send action");

endmodule

bind tftp_block_sender tfbs_checker u_chk (.*);
